/* sv/bcdrd_pkg.sv */
// Shared types and constants of the BCD length record deframer.
`default_nettype none

package bcdrd_pkg;

    localparam int MAX_RECORD_LEN_DEF = 32767;
    localparam int HEADER_BYTES_DEF   = 4;
    localparam int QUEUE_DEPTH        = 4;

    localparam logic [7:0] PREFIX_SKIP_RST = 8'd40;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_FILE_LENGTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PREFIX_SKIP = 1'b1;

    localparam logic [3:0] BCD_LIMIT = 4'hA;

    typedef enum logic [1:0] {
        PH_SKIP,
        PH_HEADER,
        PH_BODY,
        PH_STOP
    } t_phase;

    typedef enum logic [1:0] {
        KIND_HEADER,
        KIND_BODY,
        KIND_STOP
    } t_kind;

    typedef enum logic [1:0] {
        CAUSE_SHORT_TAIL,
        CAUSE_ZERO_LEN,
        CAUSE_TRUNCATED,
        CAUSE_BAD_LEN
    } t_cause;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] payload;
        logic [14:0] record_length;
        logic        record_end;
        t_cause      stop_cause;
    } t_result;

endpackage

`default_nettype wire

/* sv/bcdrd_front.sv */
// Front end: accepts file bytes, tracks the framing state and builds result items.
`default_nettype none

module bcdrd_front import bcdrd_pkg::*; #(
    parameter int MAX_RECORD_LEN = MAX_RECORD_LEN_DEF,
    parameter int HEADER_BYTES   = HEADER_BYTES_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    input  wire logic [7:0]           i_file_byte,
    input  wire logic                 i_full,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [31:0]          i_cfg_data,
    output logic                      o_push,
    output t_result                   o_push_data
);

    localparam int DEC_W = $clog2(10 ** (2 * HEADER_BYTES));
    localparam int HC_W  = (HEADER_BYTES > 1) ? $clog2(HEADER_BYTES) : 1;
    localparam int BR_W  = $clog2(MAX_RECORD_LEN + 1);
    localparam logic [HC_W-1:0] HC_LAST = HC_W'(HEADER_BYTES - 1);

    t_phase            r_phase, n_phase;
    logic [31:0]       r_byte_pos, n_byte_pos;
    logic [31:0]       r_word, n_word;
    logic [HC_W-1:0]   r_hcnt, n_hcnt;
    logic [BR_W-1:0]   r_body_rem, n_body_rem;
    logic [DEC_W-1:0]  r_dec, n_dec;
    logic              r_dec_done, n_dec_done;
    logic [31:0]       r_room, n_room;
    logic              r_room_bad, n_room_bad;
    logic [31:0]       r_start, n_start;
    logic [31:0]       r_file_length;
    logic [7:0]        r_prefix_skip;

    logic              acc;
    logic              skip_done;
    logic              first;
    logic [32:0]       diff;
    logic [32:0]       cfg_diff;
    logic [31:0]       room_base;
    logic [31:0]       room_now;
    logic              room_bad_now;
    logic [DEC_W-1:0]  dv;
    logic              dd;
    logic [31:0]       len32;

    assign acc       = i_in_valid && !i_full;
    assign skip_done = r_byte_pos >= {24'd0, r_prefix_skip};
    assign first     = (r_hcnt == '0);
    assign diff      = {1'b0, r_file_length} - {1'b0, r_byte_pos};

    // BCD digits are folded in as the header bytes arrive, high nibble first.
    always_comb begin
        dv = first ? '0 : r_dec;
        dd = first ? 1'b0 : r_dec_done;
        if (!dd) begin
            if (i_file_byte[7:4] >= BCD_LIMIT) begin
                dd = 1'b1;
            end else begin
                dv = (dv << 3) + (dv << 1) + DEC_W'(i_file_byte[7:4]);
            end
        end
        if (!dd) begin
            if (i_file_byte[3:0] >= BCD_LIMIT) begin
                dd = 1'b1;
            end else begin
                dv = (dv << 3) + (dv << 1) + DEC_W'(i_file_byte[3:0]);
            end
        end
    end

    assign len32        = 32'(dv);
    assign room_now     = first ? diff[31:0] : r_room;
    assign room_bad_now = first ? diff[32] : r_room_bad;

    always_comb begin
        n_phase     = r_phase;
        n_byte_pos  = r_byte_pos;
        n_word      = r_word;
        n_hcnt      = r_hcnt;
        n_body_rem  = r_body_rem;
        n_dec       = r_dec;
        n_dec_done  = r_dec_done;
        n_room      = r_room;
        n_room_bad  = r_room_bad;
        n_start     = r_start;
        room_base   = r_start;
        o_push      = 1'b0;
        o_push_data = '{kind: KIND_STOP, payload: 32'd0, record_length: 15'd0,
                        record_end: 1'b0, stop_cause: CAUSE_SHORT_TAIL};

        if (acc) begin
            unique case (r_phase)
                PH_SKIP, PH_HEADER: begin
                    if (r_phase == PH_SKIP && !skip_done) begin
                        n_byte_pos = r_byte_pos + 32'd1;
                    end else if (first &&
                                 (diff[32] || diff[31:0] < 32'(HEADER_BYTES))) begin
                        n_phase = PH_STOP;
                        o_push  = 1'b1;
                    end else begin
                        n_phase    = PH_HEADER;
                        n_word     = first ? {24'd0, i_file_byte} : {r_word[23:0], i_file_byte};
                        n_byte_pos = r_byte_pos + 32'd1;
                        n_dec      = dv;
                        n_dec_done = dd;
                        if (first) begin
                            n_start    = r_byte_pos;
                            room_base  = r_byte_pos;
                            n_room     = diff[31:0];
                            n_room_bad = diff[32];
                        end
                        if (r_hcnt == HC_LAST) begin
                            n_hcnt = '0;
                            o_push = 1'b1;
                            o_push_data.payload = n_word;
                            if (dv == '0) begin
                                n_phase = PH_STOP;
                                o_push_data.stop_cause = CAUSE_ZERO_LEN;
                            end else if (room_bad_now || len32 > room_now) begin
                                n_phase = PH_STOP;
                                o_push_data.stop_cause = CAUSE_TRUNCATED;
                            end else if (len32 < 32'(HEADER_BYTES) ||
                                         len32 > 32'(MAX_RECORD_LEN)) begin
                                n_phase = PH_STOP;
                                o_push_data.stop_cause = CAUSE_BAD_LEN;
                            end else begin
                                n_body_rem = BR_W'(len32 - 32'(HEADER_BYTES));
                                o_push_data.kind          = KIND_HEADER;
                                o_push_data.record_length = 15'(dv);
                                if (len32 == 32'(HEADER_BYTES)) begin
                                    o_push_data.record_end = 1'b1;
                                end else begin
                                    n_phase = PH_BODY;
                                end
                            end
                        end else begin
                            n_hcnt = r_hcnt + HC_W'(1);
                        end
                    end
                end
                PH_BODY: begin
                    n_byte_pos = r_byte_pos + 32'd1;
                    n_body_rem = r_body_rem - BR_W'(1);
                    o_push = 1'b1;
                    o_push_data.kind    = KIND_BODY;
                    o_push_data.payload = {24'd0, i_file_byte};
                    if (r_body_rem == BR_W'(1)) begin
                        o_push_data.record_end = 1'b1;
                        n_phase = PH_HEADER;
                        n_hcnt  = '0;
                    end
                end
                PH_STOP: begin
                    n_phase = PH_STOP;
                end
                default: begin
                    n_phase = PH_STOP;
                end
            endcase
        end

        // A new file length moves the room left for the record being gathered.
        cfg_diff = {1'b0, i_cfg_data} - {1'b0, room_base};
        if (i_cfg_we && i_cfg_index == CFG_FILE_LENGTH) begin
            n_room     = cfg_diff[31:0];
            n_room_bad = cfg_diff[32];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_SKIP;
            r_byte_pos    <= 32'd0;
            r_hcnt        <= '0;
            r_body_rem    <= '0;
            r_file_length <= 32'd0;
            r_prefix_skip <= PREFIX_SKIP_RST;
        end else begin
            r_phase    <= n_phase;
            r_byte_pos <= n_byte_pos;
            r_hcnt     <= n_hcnt;
            r_body_rem <= n_body_rem;
            if (i_cfg_we && i_cfg_index == CFG_FILE_LENGTH) begin
                r_file_length <= i_cfg_data;
            end
            if (i_cfg_we && i_cfg_index == CFG_PREFIX_SKIP) begin
                r_prefix_skip <= i_cfg_data[7:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_word     <= n_word;
        r_dec      <= n_dec;
        r_dec_done <= n_dec_done;
        r_room     <= n_room;
        r_room_bad <= n_room_bad;
        r_start    <= n_start;
    end

endmodule

`default_nettype wire

/* sv/bcdrd_queue.sv */
// Short result queue between the front end and the output stage.
`default_nettype none

module bcdrd_queue import bcdrd_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_result   i_push_data,
    input  wire logic i_pop,
    output logic      o_full,
    output logic      o_not_empty,
    output t_result   o_head
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_result           r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wptr, r_rptr;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              do_pop;

    assign o_full      = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_not_empty = (r_count != '0);
    assign o_head      = r_mem[r_rptr];
    assign do_pop      = i_pop && o_not_empty;

    always_comb begin
        n_count = r_count;
        if (i_push && !do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!i_push && do_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wptr <= (r_wptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_push_data;
        end
    end

endmodule

`default_nettype wire

/* sv/bcdrd_back.sv */
// Output stage: takes items from the queue and holds them until the receiver takes them.
`default_nettype none

module bcdrd_back import bcdrd_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_not_empty,
    input  t_result   i_head,
    input  wire logic i_out_stall,
    output logic      o_pop,
    output logic      o_out_valid,
    output t_result   o_result
);

    logic    r_valid;
    t_result r_result;

    // The register reloads whenever it is empty or its item is being taken.
    assign o_pop       = i_not_empty && (!r_valid || !i_out_stall);
    assign o_out_valid = r_valid;
    assign o_result    = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!r_valid || !i_out_stall) begin
            r_valid <= i_not_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_result <= i_head;
        end
    end

endmodule

`default_nettype wire

/* sv/bcd_length_record_deframer.sv */
// Top level of the BCD length prefixed record deframer.
//
// Input channel: one file byte per item on i_file_byte, handshake i_in_valid / o_in_stall.
// Output channel: one result item per cycle at most, handshake o_out_valid / i_out_stall.
// Each item is a record header (length and header word), a body byte, or a single
// stop item with a cause; after a stop all further bytes are taken and dropped.
// Configuration: i_cfg_we writes file_length (index 0) or prefix_skip (index 1).
// Throughput is one byte per cycle while o_in_stall is low: the front end classifies
// each byte in the cycle it is accepted, folding BCD digits in as header bytes arrive.
// A result is written into the four-entry queue when its byte is accepted and moves
// on into the output register, and so to the output port, when that register is free.
// When the receiver stalls, the output register holds its item and the queue fills;
// o_in_stall rises only when all four queue entries are taken.
// Synchronous reset returns to prefix skipping at byte position zero, clears the
// queue and output, and sets file_length to 0 and prefix_skip to 40.
`default_nettype none

module bcd_length_record_deframer import bcdrd_pkg::*; #(
    parameter int MAX_RECORD_LEN = MAX_RECORD_LEN_DEF,
    parameter int HEADER_BYTES   = HEADER_BYTES_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic [7:0]           i_file_byte,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic [1:0]                o_kind,
    output logic [31:0]               o_payload,
    output logic [14:0]               o_record_length,
    output logic                      o_record_end,
    output logic [1:0]                o_stop_cause,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [31:0]          i_cfg_data
);

    logic    push;
    t_result push_data;
    logic    full;
    logic    not_empty;
    t_result head;
    logic    pop;
    t_result result;

    assign o_in_stall = full;

    bcdrd_front #(
        .MAX_RECORD_LEN(MAX_RECORD_LEN),
        .HEADER_BYTES  (HEADER_BYTES)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_file_byte(i_file_byte),
        .i_full     (full),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .o_push     (push),
        .o_push_data(push_data)
    );

    bcdrd_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_data(push_data),
        .i_pop      (pop),
        .o_full     (full),
        .o_not_empty(not_empty),
        .o_head     (head)
    );

    bcdrd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_not_empty(not_empty),
        .i_head     (head),
        .i_out_stall(i_out_stall),
        .o_pop      (pop),
        .o_out_valid(o_out_valid),
        .o_result   (result)
    );

    assign o_kind          = result.kind;
    assign o_payload       = result.payload;
    assign o_record_length = result.record_length;
    assign o_record_end    = result.record_end;
    assign o_stop_cause    = result.stop_cause;

endmodule

`default_nettype wire

/* sv/bcdrd_checker.sv */
// Port-level checker for the deframer, attached to the top level by bind.
`default_nettype none

module bcdrd_checker import bcdrd_pkg::*; (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic [1:0]  o_kind,
    input wire logic [31:0] o_payload,
    input wire logic [14:0] o_record_length,
    input wire logic        o_record_end
);

    // A stalled item stays on the port unchanged.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_kind) && $stable(o_payload) && $stable(o_record_end))
        else $error("stalled output item changed");

    // Nothing follows a stop item.
    a_stop_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && o_kind == KIND_STOP |=> !o_out_valid)
        else $error("output item after stop");

    // Stop items carry no length and close no record.
    a_stop_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == KIND_STOP |-> !o_record_end && o_record_length == 15'd0)
        else $error("stop item with record fields");

    // Body items carry one byte and no length.
    a_body_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == KIND_BODY |->
            o_payload[31:8] == 24'd0 && o_record_length == 15'd0)
        else $error("body item with wide payload or length");

endmodule

bind bcd_length_record_deframer bcdrd_checker u_bcdrd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_kind         (o_kind),
    .o_payload      (o_payload),
    .o_record_length(o_record_length),
    .o_record_end   (o_record_end)
);

`default_nettype wire
